FILE: src/sct_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the shell command tokenizer.
// No dependencies; every other file but the two interfaces imports this package.
package sct_pkg;

   // Result kinds
   localparam logic [2:0] KIND_TEXT    = 3'd0;
   localparam logic [2:0] KIND_END_TOK = 3'd1;
   localparam logic [2:0] KIND_OP      = 3'd2;
   localparam logic [2:0] KIND_EOL     = 3'd3;
   localparam logic [2:0] KIND_QERR    = 3'd4;
   localparam logic [2:0] KIND_MIXERR  = 3'd5;

   // Lexer modes
   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_TEXT  = 3'd1;
   localparam logic [2:0] MODE_QUOTE = 3'd2;
   localparam logic [2:0] MODE_AFTQ  = 3'd3;
   localparam logic [2:0] MODE_OPER  = 3'd4;
   localparam logic [2:0] MODE_ERROR = 3'd5;

   // Special bytes
   localparam logic [7:0] CHAR_EOL   = 8'h00;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_PIPE  = 8'h7C;
   localparam logic [7:0] CHAR_AMP   = 8'h26;

   localparam logic [2:0] OP_NONE = 3'd4;

   // Default depth of the result queue (power of two, at least 2)
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [2:0] rec_kind;
      logic [7:0] text_byte;
      logic [2:0] op_code;
      logic       last_of_run;
   } rsp_item_type;

   // Results produced by one accepted byte (0 to 2)
   typedef struct packed {
      logic [1:0]   num;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

   // Head of the result queue
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } head_type;

   function automatic logic is_sep(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_NL) || (c == CHAR_TAB);
   endfunction

   // Operator index 0..3, or OP_NONE
   function automatic logic [2:0] op_index(input logic [7:0] c);
      logic [2:0] k;
      case (c)
         CHAR_GT:   k = 3'd0;
         CHAR_LT:   k = 3'd1;
         CHAR_PIPE: k = 3'd2;
         CHAR_AMP:  k = 3'd3;
         default:   k = OP_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] op_byte(input logic [1:0] p);
      logic [7:0] b;
      case (p)
         2'd0:    b = CHAR_GT;
         2'd1:    b = CHAR_LT;
         2'd2:    b = CHAR_PIPE;
         default: b = CHAR_AMP;
      endcase
      return b;
   endfunction

   function automatic rsp_item_type mk_item(input logic [2:0] kind,
                                            input logic [7:0] tb,
                                            input logic [2:0] op);
      rsp_item_type r;
      r.rec_kind    = kind;
      r.text_byte   = tb;
      r.op_code     = op;
      r.last_of_run = 1'b0;
      return r;
   endfunction

endpackage

FILE: src/sct_req_if.sv
`timescale 1ns / 1ps
// Byte channel into the tokenizer: valid/ready plus one command-line byte.
// No dependencies.
interface sct_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;

   modport source (output valid, output char_byte, input ready);
   modport sink (input valid, input char_byte, output ready);
endinterface

FILE: src/sct_rsp_if.sv
`timescale 1ns / 1ps
// Result channel out of the tokenizer: valid/ready plus the result fields.
// No dependencies.
interface sct_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] rec_kind;
   logic [7:0] text_byte;
   logic [2:0] op_code;
   logic       last_of_run;

   modport source (output valid, output rec_kind, output text_byte, output op_code,
                   output last_of_run, input ready);
   modport sink (input valid, input rec_kind, input text_byte, input op_code,
                 input last_of_run, output ready);
endinterface

FILE: src/shell_command_tokenizer_unit.sv
`timescale 1ns / 1ps
// Top level of the shell command tokenizer: front end, result queue, back end.
// Depends on sct_pkg, sct_req_if, sct_rsp_if, sct_front, sct_queue, sct_back.
//
//   channel  role    transfer carries
//   req_if   sink    one command-line byte (char_byte), byte 0 ends the line
//   rsp_if   source  one result (rec_kind, text_byte, op_code, last_of_run)
//
// Cycles: one byte per cycle is taken while the queue has room for two results;
//   the first result of a byte passes through the queue write and then the
//   output register load before it is presented on rsp_if.
// Sustained rate is set by the single result port: one result transfer per cycle
//   while rsp_if.ready is high, so bytes that give two results (token end plus
//   line end, and so on) need the queue of QUEUE_DEPTH entries to absorb the burst.
// Reset (synchronous, active high) returns the lexer to idle between tokens and
//   empties the queue and output register.
// Stalls: rsp_if.ready low holds the output register; the queue fills and then
//   req_if.ready drops, independent of lexer state.
module shell_command_tokenizer_unit #(
   parameter int QUEUE_DEPTH = sct_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   sct_req_if.sink    req_if,
   sct_rsp_if.source  rsp_if
);
   import sct_pkg::*;

   push_type push;
   head_type head;
   logic     room_ok;
   logic     head_pop;

   // Classify bytes and advance the lexer; emit results into the queue
   sct_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .room_ok (room_ok),
      .push    (push)
   );

   // Decouple the two sides: hold bursts of up to two results per byte
   sct_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room_ok  (room_ok),
      .head     (head),
      .head_pop (head_pop)
   );

   // Drive the result channel from a register; advance whenever it frees
   sct_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .head_pop (head_pop),
      .rsp_if   (rsp_if)
   );
endmodule

FILE: src/sct_front.sv
`timescale 1ns / 1ps
// Front end: accepts bytes, runs the lexer state and emits 0 to 2 results per byte.
// Depends on sct_pkg and sct_req_if.
module sct_front (
   input  logic               clock,
   input  logic               reset,
   sct_req_if.sink            req_if,
   input  logic               room_ok,
   output sct_pkg::push_type  push
);
   import sct_pkg::*;

   typedef struct packed {
      logic [2:0]   mode;
      logic [1:0]   pend;
      logic         emit;
      rsp_item_type item;
   } idle_type;

   logic [2:0]   mode_ff, mode_in;
   logic [1:0]   pend_ff, pend_in;
   logic [7:0]   c;
   logic [2:0]   k;
   logic         is_q, is_op, is_txt, accept;
   rsp_item_type items [2];
   logic [1:0]   n;
   idle_type     fi;

   function automatic idle_type from_idle(input logic [7:0] ch, input logic [1:0] pend);
      idle_type r;
      logic [2:0] kk;
      kk = op_index(ch);
      r.mode = MODE_IDLE;
      r.pend = pend;
      r.emit = 1'b0;
      r.item = mk_item(KIND_TEXT, 8'd0, 3'd0);
      if (ch == CHAR_EOL) begin
         r.emit = 1'b1;
         r.item = mk_item(KIND_EOL, 8'd0, 3'd0);
      end else if (ch == CHAR_QUOTE) begin
         r.mode = MODE_QUOTE;
      end else if (kk != OP_NONE) begin
         r.pend = kk[1:0];
         r.mode = MODE_OPER;
      end else if (!is_sep(ch)) begin
         r.emit = 1'b1;
         r.item = mk_item(KIND_TEXT, ch, 3'd0);
         r.mode = MODE_TEXT;
      end
      return r;
   endfunction

   assign c      = req_if.char_byte;
   assign k      = op_index(c);
   assign is_q   = (c == CHAR_QUOTE);
   assign is_op  = (k != OP_NONE);
   assign is_txt = (c != CHAR_EOL) && !is_q && !is_sep(c) && !is_op;
   assign fi     = from_idle(c, pend_ff);

   assign req_if.ready = room_ok;
   assign accept       = req_if.valid && room_ok;

   always_comb begin
      items[0] = mk_item(KIND_TEXT, 8'd0, 3'd0);
      items[1] = mk_item(KIND_TEXT, 8'd0, 3'd0);
      n        = 2'd0;
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      case (mode_ff)
         MODE_TEXT, MODE_AFTQ: begin
            if (mode_ff == MODE_TEXT && is_q) begin
               mode_in = MODE_QUOTE;
            end else if (is_txt) begin
               items[0] = mk_item(KIND_TEXT, c, 3'd0);
               n        = 2'd1;
               mode_in  = MODE_TEXT;
            end else begin
               // end the token, then handle the byte as from idle
               items[0] = mk_item(KIND_END_TOK, 8'd0, 3'd0);
               items[1] = fi.item;
               n        = fi.emit ? 2'd2 : 2'd1;
               mode_in  = fi.mode;
               pend_in  = fi.pend;
            end
         end
         MODE_QUOTE: begin
            if (c == CHAR_EOL) begin
               items[0] = mk_item(KIND_QERR, 8'd0, 3'd0);
               items[1] = mk_item(KIND_EOL, 8'd0, 3'd0);
               n        = 2'd2;
               mode_in  = MODE_IDLE;
            end else if (is_q) begin
               mode_in = MODE_AFTQ;
            end else begin
               items[0] = mk_item(KIND_TEXT, c, 3'd0);
               n        = 2'd1;
            end
         end
         MODE_OPER: begin
            if (c == op_byte(pend_ff)) begin
               items[0] = mk_item(KIND_OP, 8'd0, {pend_ff, 1'b1});
               n        = 2'd1;
               mode_in  = MODE_IDLE;
            end else if (is_op) begin
               items[0] = mk_item(KIND_MIXERR, 8'd0, 3'd0);
               n        = 2'd1;
               mode_in  = MODE_ERROR;
            end else begin
               items[0] = mk_item(KIND_OP, 8'd0, {pend_ff, 1'b0});
               items[1] = fi.item;
               n        = fi.emit ? 2'd2 : 2'd1;
               mode_in  = fi.mode;
               pend_in  = fi.pend;
            end
         end
         MODE_ERROR: begin
            if (c == CHAR_EOL) begin
               items[0] = mk_item(KIND_EOL, 8'd0, 3'd0);
               n        = 2'd1;
               mode_in  = MODE_IDLE;
            end
         end
         default: begin
            items[0] = fi.item;
            n        = fi.emit ? 2'd1 : 2'd0;
            mode_in  = fi.mode;
            pend_in  = fi.pend;
         end
      endcase
      // flag the final result of this byte
      if (n == 2'd1) begin
         items[0].last_of_run = 1'b1;
      end else if (n == 2'd2) begin
         items[1].last_of_run = 1'b1;
      end
   end

   assign push.num   = accept ? n : 2'd0;
   assign push.item0 = items[0];
   assign push.item1 = items[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pend_ff <= 2'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
      end
   end

   a_eol_gives_result: assert property (@(posedge clock) disable iff (reset)
      (accept && c == CHAR_EOL) |-> (push.num != 2'd0))
      else $error("line end produced no result");

   a_error_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff == MODE_ERROR && c != CHAR_EOL) |-> (push.num == 2'd0))
      else $error("result emitted while skipping after an error");

   a_push_gated: assert property (@(posedge clock) disable iff (reset)
      (push.num != 2'd0) |-> room_ok)
      else $error("push without queue room");
endmodule

FILE: src/sct_queue.sv
`timescale 1ns / 1ps
// Result queue between front and back: up to two pushes and one pop per cycle.
// Depends on sct_pkg.
module sct_queue #(
   parameter int DEPTH = sct_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  sct_pkg::push_type  push,
   output logic               room_ok,
   output sct_pkg::head_type  head,
   input  logic               head_pop
);
   import sct_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_item_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign room_ok    = (count_ff <= CNT_W'(DEPTH - 2));
   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];
   assign pop        = head.valid && head_pop;

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.num);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push.num) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.num == 2'd2) begin
         slot_ff[wr_ptr_ff + PTR_W'(1)] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue overflow");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == PTR_W'(count_ff))
      else $error("queue pointers disagree with fill count");
endmodule

FILE: src/sct_back.sv
`timescale 1ns / 1ps
// Back end: output register that drains the result queue onto the result channel.
// Depends on sct_pkg and sct_rsp_if.
module sct_back (
   input  logic               clock,
   input  logic               reset,
   input  sct_pkg::head_type  head,
   output logic               head_pop,
   sct_rsp_if.source          rsp_if
);
   import sct_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;
   logic         load;

   assign head_pop = !valid_ff || rsp_if.ready;
   assign load     = head.valid && head_pop;
   assign valid_in = load || (valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= head.item;
      end
   end

   assign rsp_if.valid       = valid_ff;
   assign rsp_if.rec_kind    = item_ff.rec_kind;
   assign rsp_if.text_byte   = item_ff.text_byte;
   assign rsp_if.op_code     = item_ff.op_code;
   assign rsp_if.last_of_run = item_ff.last_of_run;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded result not presented");
endmodule

FILE: verif/sct_token_checker.sv
`timescale 1ns / 1ps
// Token stream checker for shell_command_tokenizer_unit: predicts the result stream
// from accepted bytes and compares it with the results that leave the block.
// Depends on sct_pkg, sct_req_if, sct_rsp_if.
module sct_token_checker (
   input  logic clock,
   input  logic reset,
   sct_req_if   req_mon,
   sct_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   results_pending
);
   import sct_pkg::*;

   // operator classes, also the high bits of op_code
   localparam logic [2:0] OPER_GT   = 3'd0;
   localparam logic [2:0] OPER_LT   = 3'd1;
   localparam logic [2:0] OPER_PIPE = 3'd2;
   localparam logic [2:0] OPER_AMP  = 3'd3;
   localparam logic [2:0] NOT_OPER  = 3'd4;

   logic [2:0]   lex_mode;
   logic [1:0]   lex_pend;
   rsp_item_type token_stream_q[$];
   rsp_item_type byte_results[$];

   initial begin
      mismatch_count  = 0;
      results_pending = 0;
      lex_mode        = MODE_IDLE;
      lex_pend        = 2'd0;
   end

   function automatic bit is_blank(input logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_NL || c == CHAR_TAB;
   endfunction

   function automatic logic [2:0] oper_class(input logic [7:0] c);
      case (c)
         CHAR_GT:   return OPER_GT;
         CHAR_LT:   return OPER_LT;
         CHAR_PIPE: return OPER_PIPE;
         CHAR_AMP:  return OPER_AMP;
         default:   return NOT_OPER;
      endcase
   endfunction

   function automatic bit is_word_byte(input logic [7:0] c);
      return c != CHAR_EOL && c != CHAR_QUOTE && !is_blank(c) && oper_class(c) == NOT_OPER;
   endfunction

   task automatic emit(input logic [2:0] kind, input logic [7:0] b, input logic [2:0] op);
      rsp_item_type r;
      r.rec_kind    = kind;
      r.text_byte   = b;
      r.op_code     = op;
      r.last_of_run = 1'b0;
      byte_results.push_back(r);
   endtask

   // byte seen between tokens
   task automatic open_token(input logic [7:0] c);
      logic [2:0] cls;
      cls      = oper_class(c);
      lex_mode = MODE_IDLE;
      if (c == CHAR_EOL) begin
         emit(KIND_EOL, 8'h00, 3'd0);
      end else if (c == CHAR_QUOTE) begin
         lex_mode = MODE_QUOTE;
      end else if (cls != NOT_OPER) begin
         lex_pend = cls[1:0];
         lex_mode = MODE_OPER;
      end else if (!is_blank(c)) begin
         emit(KIND_TEXT, c, 3'd0);
         lex_mode = MODE_TEXT;
      end
   endtask

   task automatic lex_byte(input logic [7:0] c);
      logic [2:0] cls;
      cls = oper_class(c);
      byte_results.delete();
      case (lex_mode)
         MODE_TEXT: begin
            if (c == CHAR_QUOTE) begin
               lex_mode = MODE_QUOTE;
            end else if (is_word_byte(c)) begin
               emit(KIND_TEXT, c, 3'd0);
            end else begin
               emit(KIND_END_TOK, 8'h00, 3'd0);
               open_token(c);
            end
         end
         MODE_QUOTE: begin
            if (c == CHAR_EOL) begin
               emit(KIND_QERR, 8'h00, 3'd0);
               emit(KIND_EOL, 8'h00, 3'd0);
               lex_mode = MODE_IDLE;
            end else if (c == CHAR_QUOTE) begin
               lex_mode = MODE_AFTQ;
            end else begin
               emit(KIND_TEXT, c, 3'd0);
            end
         end
         MODE_AFTQ: begin
            if (is_word_byte(c)) begin
               emit(KIND_TEXT, c, 3'd0);
               lex_mode = MODE_TEXT;
            end else begin
               emit(KIND_END_TOK, 8'h00, 3'd0);
               open_token(c);
            end
         end
         MODE_OPER: begin
            if (cls == {1'b0, lex_pend}) begin
               emit(KIND_OP, 8'h00, {lex_pend, 1'b1});
               lex_mode = MODE_IDLE;
            end else if (cls != NOT_OPER) begin
               emit(KIND_MIXERR, 8'h00, 3'd0);
               lex_mode = MODE_ERROR;
            end else begin
               emit(KIND_OP, 8'h00, {lex_pend, 1'b0});
               open_token(c);
            end
         end
         MODE_ERROR: begin
            if (c == CHAR_EOL) begin
               emit(KIND_EOL, 8'h00, 3'd0);
               lex_mode = MODE_IDLE;
            end
         end
         default: begin
            open_token(c);
         end
      endcase
      if (byte_results.size() > 0) begin
         byte_results[byte_results.size() - 1].last_of_run = 1'b1;
      end
      foreach (byte_results[i]) begin
         token_stream_q.push_back(byte_results[i]);
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want_v,
                              input logic [7:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
         mismatch_count++;
      end
   endtask

   task automatic check_result();
      rsp_item_type want;
      if (token_stream_q.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual kind %0h byte %0h op %0h last %0h",
                  $time, rsp_mon.rec_kind, rsp_mon.text_byte, rsp_mon.op_code,
                  rsp_mon.last_of_run);
         mismatch_count++;
      end else begin
         want = token_stream_q.pop_front();
         check_field("rec_kind", {5'd0, want.rec_kind}, {5'd0, rsp_mon.rec_kind});
         check_field("text_byte", want.text_byte, rsp_mon.text_byte);
         check_field("op_code", {5'd0, want.op_code}, {5'd0, rsp_mon.op_code});
         check_field("last_of_run", {7'd0, want.last_of_run}, {7'd0, rsp_mon.last_of_run});
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lex_mode = MODE_IDLE;
         lex_pend = 2'd0;
         token_stream_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            lex_byte(req_mon.char_byte);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_result();
         end
      end
      results_pending = token_stream_q.size();
   end

endmodule

FILE: verif/shell_command_tokenizer_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for shell_command_tokenizer_unit: clock, reset, byte stimulus and
// result-side back-pressure, with sct_token_checker doing prediction and compare.
// Depends on sct_pkg, sct_req_if, sct_rsp_if, sct_token_checker and the block.
module shell_command_tokenizer_unit_tb;
   import sct_pkg::*;

   localparam int CYCLE_LIMIT    = 300000;
   localparam int QUIET_CYCLES   = 12;   // output queue plus register, with margin
   localparam int BYTES_PER_PHASE = 45;
   localparam int NUM_PHASES     = 4;

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   mismatch_count;
   int   results_pending;

   // idling plan per phase: none, sender idle, receiver stalling, both
   int   idle_plan[NUM_PHASES]  = '{0, 80, 0, 30};
   int   stall_plan[NUM_PHASES] = '{0, 0, 80, 30};
   int   send_idle_pct;
   int   stall_pct;
   int   hold_len;
   int   bytes_sent;

   logic [7:0] line_buf[$];
   logic [7:0] oper_chars[4]  = '{CHAR_GT, CHAR_LT, CHAR_PIPE, CHAR_AMP};
   logic [7:0] blank_chars[3] = '{CHAR_SPACE, CHAR_NL, CHAR_TAB};
   logic [7:0] special_chars[8] = '{CHAR_QUOTE, CHAR_GT, CHAR_LT, CHAR_PIPE, CHAR_AMP,
                                    CHAR_SPACE, CHAR_NL, CHAR_TAB};

   sct_req_if req_ch();
   sct_rsp_if rsp_ch();

   shell_command_tokenizer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   sct_token_checker token_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bound the run: a hang anywhere ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[shell_command_tokenizer_unit] ERROR");
         $finish;
      end
   end

   // Result side: stall at the phase rate, or hold off for a counted stretch when
   // asked so the internal queue fills and the byte channel backs up.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_len > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_len--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Any byte that is not a separator, quote, operator byte or line end.
   function automatic logic [7:0] pick_word_byte();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(1, 255));
      end while (c == CHAR_QUOTE || c == CHAR_SPACE || c == CHAR_NL || c == CHAR_TAB ||
                 c == CHAR_GT || c == CHAR_LT || c == CHAR_PIPE || c == CHAR_AMP);
      return c;
   endfunction

   // Anything allowed between quotes: separators and operator bytes too.
   function automatic logic [7:0] pick_quoted_byte();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(1, 255));
      end while (c == CHAR_QUOTE);
      return c;
   endfunction

   // Offer one byte and hold it until the transfer. Called at a falling edge,
   // returns at a falling edge with valid still high; valid only drops on an idle
   // gap or a drain, so it never sees two assignments in one step.
   task automatic send_byte(input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_byte <= c;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_line();
      foreach (line_buf[i]) begin
         send_byte(line_buf[i]);
      end
   endtask

   // Stop offering, wait out every expected result, then let the pipeline settle
   // in case the last bytes produced nothing.
   task automatic drain_all();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (results_pending != 0);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   function automatic int op_slot(input logic [7:0] c);
      foreach (oper_chars[i]) if (oper_chars[i] == c) return i;
      return 0;
   endfunction

   // Mostly well-formed lines with random content; some raw noise, some lines
   // broken by an open quote or a clash of operator bytes.
   task automatic build_line();
      int n_tok;
      int len;
      logic [7:0] op;
      line_buf.delete();
      if ($urandom_range(99) < 15) begin
         len = $urandom_range(1, 10);
         repeat (len) begin
            if ($urandom_range(1))
               line_buf.push_back(special_chars[$urandom_range(7)]);
            else
               line_buf.push_back(8'($urandom_range(255)));
         end
      end else begin
         n_tok = $urandom_range(1, 5);
         repeat (n_tok) begin
            case ($urandom_range(5))
               0, 1: begin
                  repeat ($urandom_range(1, 4)) line_buf.push_back(pick_word_byte());
               end
               2: begin
                  line_buf.push_back(CHAR_QUOTE);
                  repeat ($urandom_range(0, 4)) line_buf.push_back(pick_quoted_byte());
                  line_buf.push_back(CHAR_QUOTE);
               end
               3: begin
                  // text joined to a quoted section before it, and sometimes after it
                  repeat ($urandom_range(1, 2)) line_buf.push_back(pick_word_byte());
                  line_buf.push_back(CHAR_QUOTE);
                  repeat ($urandom_range(0, 3)) line_buf.push_back(pick_quoted_byte());
                  line_buf.push_back(CHAR_QUOTE);
                  repeat ($urandom_range(0, 2)) line_buf.push_back(pick_word_byte());
               end
               4: begin
                  op = oper_chars[$urandom_range(3)];
                  line_buf.push_back(op);
                  if ($urandom_range(1)) line_buf.push_back(op);
               end
               default: begin
                  // empty quotes, sometimes straight into a second quoted token
                  line_buf.push_back(CHAR_QUOTE);
                  line_buf.push_back(CHAR_QUOTE);
                  if ($urandom_range(1)) begin
                     line_buf.push_back(CHAR_QUOTE);
                     line_buf.push_back(pick_quoted_byte());
                     line_buf.push_back(CHAR_QUOTE);
                  end
               end
            endcase
            if ($urandom_range(99) < 85) begin
               repeat ($urandom_range(1, 2)) line_buf.push_back(blank_chars[$urandom_range(2)]);
            end
         end
         case ($urandom_range(19))
            0: begin
               line_buf.push_back(CHAR_QUOTE);
               line_buf.push_back(pick_quoted_byte());
            end
            1: begin
               op = oper_chars[$urandom_range(3)];
               line_buf.push_back(op);
               line_buf.push_back(oper_chars[($urandom_range(1, 3) + op_slot(op)) % 4]);
               line_buf.push_back(pick_word_byte());
            end
            default: ;
         endcase
      end
      line_buf.push_back(CHAR_EOL);
   endtask

   initial begin : stimulus
      int phase_idx;
      int phase_start;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.char_byte = 8'h00;
      send_idle_pct    = 0;
      stall_pct        = 0;
      hold_len         = 0;
      bytes_sent       = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: byte extremes, text joined across quotes, a tripled greater-than
      // operator, mixed operators with a byte skipped before line end.
      line_buf = {8'hFF, CHAR_QUOTE, 8'h01, CHAR_QUOTE, 8'h80, CHAR_TAB, CHAR_GT, CHAR_GT,
                  CHAR_GT, CHAR_LT, 8'h7F, CHAR_EOL};
      send_line();
      // Empty quotes, quote right after quote, doubled less-than, pipe and ampersand, single pipe
      // and ampersand, then a quote left open at line end.
      line_buf = {CHAR_QUOTE, CHAR_QUOTE, CHAR_QUOTE, CHAR_QUOTE, CHAR_LT, CHAR_LT, CHAR_PIPE,
                  CHAR_PIPE, CHAR_AMP, CHAR_AMP, CHAR_PIPE, CHAR_SPACE, CHAR_AMP, CHAR_QUOTE,
                  CHAR_EOL};
      send_line();
      // Single greater and less than, the latter closed by line end.
      line_buf = {CHAR_GT, CHAR_NL, CHAR_LT, CHAR_EOL};
      send_line();
      drain_all();

      // Back-pressure: hold the result side off while bytes keep coming.
      hold_len    = 150;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 30) begin
         build_line();
         send_line();
      end
      drain_all();

      for (phase_idx = 0; phase_idx < NUM_PHASES; phase_idx++) begin
         send_idle_pct = idle_plan[phase_idx];
         stall_pct     = stall_plan[phase_idx];
         phase_start   = bytes_sent;
         while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
            build_line();
            send_line();
         end
         drain_all();
      end

      if (mismatch_count == 0) begin
         $display("[shell_command_tokenizer_unit] OK");
      end else begin
         $display("[shell_command_tokenizer_unit] ERROR");
      end
      $finish;
   end

endmodule

FILE: shell_command_tokenizer_unit.f
src/sct_pkg.sv
src/sct_req_if.sv
src/sct_rsp_if.sv
src/sct_front.sv
src/sct_queue.sv
src/sct_back.sv
src/shell_command_tokenizer_unit.sv
verif/sct_token_checker.sv
verif/shell_command_tokenizer_unit_tb.sv
